### sv/polynomial_add_and_multiply_defines.svh
// Assertion macros for the polynomial add and multiply block.
// Used by the RTL files that check their own logic; no other dependencies.
`ifndef POLYNOMIAL_ADD_AND_MULTIPLY_DEFINES_SVH
`define POLYNOMIAL_ADD_AND_MULTIPLY_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define PAM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PAM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PAM_ASSERT_IMP(lbl, ante, cons, msg)
`define PAM_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### sv/pam_pkg.sv
// Shared types and constants of the polynomial add and multiply block.
// No dependencies; used by the sequencer and the top level.
package pam_pkg;

    localparam int MAX_LEN_DEF = 16;

    localparam int LEN_W  = 5;
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 4;
    localparam int COEF_W = 16;
    localparam int RIDX_W = 5;
    localparam int VAL_W  = 40;
    localparam int TERM_W = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE     = 2'd2;

    localparam logic KIND_SUM  = 1'b0;
    localparam logic KIND_PROD = 1'b1;

    localparam logic CFG_LEN_FIRST  = 1'b0;
    localparam logic CFG_LEN_SECOND = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_CONV
    } t_state;

    // control that travels with each memory read down the datapath
    typedef struct packed {
        logic              valid;
        logic              kind;
        logic              use_a;
        logic              use_b;
        logic              first;
        logic              last_term;
        logic              last_run;
        logic [RIDX_W-1:0] ridx;
    } t_tag;

endpackage

### sv/polynomial_add_and_multiply.sv
// Polynomial add and multiply: top level with config, coefficient RAMs,
// MAC datapath and output register. Depends on pam_pkg, pam_ram, pam_seq.
//
// Loads are accepted back to back and go straight into one of two coefficient
// RAMs (one write and one read port each). A compute item with lengths n1
// and n2 sends max(n1,n2) sum reads and n1*n2 product reads through the
// pipeline, which holds while the output is stalled: the sequencer
// issues one read pair per cycle to the two RAMs while not stalled, and a single 16x16
// multiplier takes one product per cycle into a 40-bit accumulator. The
// input is not ready from the compute item until its last read has left
// the pipeline; a finished result may still wait in the output register.
`include "polynomial_add_and_multiply_defines.svh"

module polynomial_add_and_multiply #(
    parameter int MAX_LEN = pam_pkg::MAX_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [4:0]  i_cfg_data,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // coef_index[3:0], coef_value[19:4], zero
    input  logic [1:0]  i_s_axis_tuser,  // cmd[1:0]
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // result_index[4:0], result_value[44:5], zero
    output logic        o_m_axis_tuser,  // kind[0]
    output logic        o_m_axis_tlast   // last
);

    localparam int AW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW_    = pam_pkg::COEF_W;
    localparam int TW     = pam_pkg::TERM_W;
    localparam int VW     = pam_pkg::VAL_W;
    localparam int RW     = pam_pkg::RIDX_W;
    localparam int IW     = pam_pkg::IDX_W;

    // configuration
    logic [pam_pkg::LEN_W-1:0] r_len_first, r_len_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_first  <= pam_pkg::LEN_W'(1);
            r_len_second <= pam_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == pam_pkg::CFG_LEN_FIRST) begin
                r_len_first <= i_cfg_data;
            end else begin
                r_len_second <= i_cfg_data;
            end
        end
    end

    // input decode
    logic [pam_pkg::CMD_W-1:0] in_cmd;
    logic [IW-1:0]             in_idx;
    logic [CW_-1:0]            in_val;
    logic [AW+IW-1:0]          idx_ext;
    logic                      in_accept, idx_ok, we_a, we_b, start;
    logic                      seq_idle, en;

    pam_pkg::t_tag seq_tag;
    pam_pkg::t_tag r_s1, r_s2;
    logic [AW-1:0] addr_a, addr_b;
    logic [CW_-1:0] rd_a, rd_b;

    assign in_cmd  = i_s_axis_tuser;
    assign in_idx  = i_s_axis_tdata[IW-1:0];
    assign in_val  = i_s_axis_tdata[IW+CW_-1:IW];
    assign idx_ext = {{AW{1'b0}}, in_idx};

    assign o_s_axis_tready = seq_idle && !r_s1.valid && !r_s2.valid;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        idx_ok = (int'(in_idx) < MAX_LEN);
        we_a   = in_accept && idx_ok && (in_cmd == pam_pkg::CMD_LOAD_FIRST);
        we_b   = in_accept && idx_ok && (in_cmd == pam_pkg::CMD_LOAD_SECOND);
        start  = in_accept && (in_cmd == pam_pkg::CMD_COMPUTE);
    end

    // advance the whole pipeline only while the output register can take an item
    assign en = !o_m_axis_tvalid || i_m_axis_tready;

    pam_seq #(
        .MAX_LEN(MAX_LEN)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_en         (en),
        .i_len_first  (r_len_first),
        .i_len_second (r_len_second),
        .o_idle       (seq_idle),
        .o_tag        (seq_tag),
        .o_addr_a     (addr_a),
        .o_addr_b     (addr_b)
    );

    pam_ram #(
        .WIDTH(CW_),
        .DEPTH(MAX_LEN)
    ) u_ram_first (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (in_val),
        .i_re    (en),
        .i_raddr (addr_a),
        .o_rdata (rd_a)
    );

    pam_ram #(
        .WIDTH(CW_),
        .DEPTH(MAX_LEN)
    ) u_ram_second (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (in_val),
        .i_re    (en),
        .i_raddr (addr_b),
        .o_rdata (rd_b)
    );

    // stage 2: sum or product term
    logic signed [CW_-1:0] a_m, b_m;
    logic signed [TW-1:0]  term, r_term;

    always_comb begin
        a_m = r_s1.use_a ? $signed(rd_a) : '0;
        b_m = r_s1.use_b ? $signed(rd_b) : '0;
        if (r_s1.kind == pam_pkg::KIND_SUM) begin
            term = TW'(a_m) + TW'(b_m);
        end else begin
            term = TW'(a_m) * TW'(b_m);
        end
    end

    // stage 3: accumulate, load output register on the last term
    logic signed [VW-1:0] r_acc, acc_sum;
    logic [RW-1:0]        r_out_idx;
    logic [VW-1:0]        r_out_val;
    logic                 r_out_valid, r_out_kind, r_out_last;

    assign acc_sum = (r_s2.first ? '0 : r_acc) + VW'(r_term);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1        <= seq_tag;
            r_s2        <= r_s1;
            r_out_valid <= r_s2.valid && r_s2.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_term <= term;
            if (r_s2.valid) begin
                r_acc <= acc_sum;
            end
            if (r_s2.valid && r_s2.last_term) begin
                r_out_idx  <= r_s2.ridx;
                r_out_val  <= acc_sum;
                r_out_kind <= r_s2.kind;
                r_out_last <= r_s2.last_run;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_val, r_out_idx};
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;

    `PAM_ASSERT_IMP(a_last_is_prod, o_m_axis_tvalid && o_m_axis_tlast,
                    o_m_axis_tuser == pam_pkg::KIND_PROD, "last marks a sum item")
    `PAM_ASSERT_IMP(a_load_when_idle, we_a || we_b,
                    seq_idle && !r_s1.valid && !r_s2.valid, "RAM write during compute")
    `PAM_ASSERT_NXT(a_term_reaches_out, en && r_s2.valid && r_s2.last_term,
                    o_m_axis_tvalid, "finished term lost")
    `PAM_ASSERT_NXT(a_stall_freezes, o_m_axis_tvalid && !i_m_axis_tready,
                    $stable(r_s1) && $stable(r_s2) && $stable(r_acc),
                    "pipeline moved while stalled")

endmodule

### sv/pam_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/pam_seq.sv
// Read sequencer: walks the sum pass and the convolution terms and issues
// one memory read pair with its tag per advance. Depends on pam_pkg.
module pam_seq #(
    parameter int MAX_LEN = pam_pkg::MAX_LEN_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_start,
    input  logic                                     i_en,
    input  logic [pam_pkg::LEN_W-1:0]                i_len_first,
    input  logic [pam_pkg::LEN_W-1:0]                i_len_second,
    output logic                                     o_idle,
    output pam_pkg::t_tag                            o_tag,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] o_addr_a,
    output logic [(MAX_LEN > 1 ? $clog2(MAX_LEN) : 1)-1:0] o_addr_b
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(2 * MAX_LEN);
    localparam int LW = pam_pkg::LEN_W;
    localparam int RW = pam_pkg::RIDX_W;

    pam_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;

    logic [LW-1:0]   len1, len2;
    logic [CW-1:0]   n1, n2, nmax, n3;
    logic [CW-1:0]   jhi, jlo_cur, jlo_nxt, ip1, bidx;
    logic [CW+RW-1:0] i_ext;
    logic            term_end, run_end;

    // clamp lengths to 1..MAX_LEN
    always_comb begin
        len1 = i_len_first;
        len2 = i_len_second;
        if (i_len_first == '0) begin
            len1 = LW'(1);
        end else if (i_len_first > LW'(MAX_LEN)) begin
            len1 = LW'(MAX_LEN);
        end
        if (i_len_second == '0) begin
            len2 = LW'(1);
        end else if (i_len_second > LW'(MAX_LEN)) begin
            len2 = LW'(MAX_LEN);
        end
        n1   = CW'(len1);
        n2   = CW'(len2);
        nmax = (n1 > n2) ? n1 : n2;
        n3   = n1 + n2 - CW'(1);
    end

    // term range of output i: j from max(0, i-n2+1) to min(i, n1-1)
    always_comb begin
        ip1      = r_i + CW'(1);
        jhi      = (r_i < n1) ? r_i : n1 - CW'(1);
        jlo_cur  = (r_i >= n2) ? r_i - n2 + CW'(1) : '0;
        jlo_nxt  = (ip1 >= n2) ? ip1 - n2 + CW'(1) : '0;
        term_end = (r_j == jhi);
        run_end  = term_end && (r_i == n3 - CW'(1));
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        unique case (r_state)
            pam_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = pam_pkg::ST_SUM;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            pam_pkg::ST_SUM: begin
                if (i_en) begin
                    if (r_i == nmax - CW'(1)) begin
                        n_state = pam_pkg::ST_CONV;
                        n_i     = '0;
                        n_j     = '0;
                    end else begin
                        n_i = ip1;
                    end
                end
            end
            pam_pkg::ST_CONV: begin
                if (i_en) begin
                    if (run_end) begin
                        n_state = pam_pkg::ST_IDLE;
                    end else if (term_end) begin
                        n_i = ip1;
                        n_j = jlo_nxt;
                    end else begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            default: n_state = pam_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        i_ext          = {{RW{1'b0}}, r_i};
        bidx           = r_i - r_j;
        o_idle         = (r_state == pam_pkg::ST_IDLE);
        o_tag          = '0;
        o_tag.ridx     = i_ext[RW-1:0];
        o_addr_a       = r_j[AW-1:0];
        o_addr_b       = bidx[AW-1:0];
        unique case (r_state)
            pam_pkg::ST_IDLE: begin
                o_tag.valid = 1'b0;
            end
            pam_pkg::ST_SUM: begin
                o_addr_a        = r_i[AW-1:0];
                o_addr_b        = r_i[AW-1:0];
                o_tag.valid     = 1'b1;
                o_tag.kind      = pam_pkg::KIND_SUM;
                o_tag.use_a     = (r_i < n1);
                o_tag.use_b     = (r_i < n2);
                o_tag.first     = 1'b1;
                o_tag.last_term = 1'b1;
                o_tag.last_run  = 1'b0;
            end
            pam_pkg::ST_CONV: begin
                o_tag.valid     = 1'b1;
                o_tag.kind      = pam_pkg::KIND_PROD;
                o_tag.use_a     = 1'b1;
                o_tag.use_b     = 1'b1;
                o_tag.first     = (r_j == jlo_cur);
                o_tag.last_term = term_end;
                o_tag.last_run  = run_end;
            end
            default: o_tag.valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pam_pkg::ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

endmodule
